FILE: src/mjq_pkg.sv
// Shared command codes and constants for the multilevel job queue.
`timescale 1ns / 1ps
package mjq_pkg;

  // Command codes carried by the input item.
  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_TOP   = 3'd2,
    CMD_NEXT  = 3'd3,
    CMD_NEXTL = 3'd4,
    CMD_FIRST = 3'd5,
    CMD_COUNT = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_e;

  localparam int unsigned JobIdW  = 8;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned SubW    = 2;
  localparam int unsigned CountW  = 9;

endpackage

FILE: src/mjq_in_if.sv
// Command channel of the multilevel job queue.
`timescale 1ns / 1ps
interface mjq_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   command;
  logic [mjq_pkg::JobIdW-1:0]   job_id;
  logic [mjq_pkg::LevelW-1:0]   priority_req;
  logic [mjq_pkg::SubW-1:0]     sub_priority;

  modport source (output valid, command, job_id, priority_req, sub_priority, input ready);
  modport sink   (input valid, command, job_id, priority_req, sub_priority, output ready);
endinterface

FILE: src/mjq_out_if.sv
// Result channel of the multilevel job queue.
`timescale 1ns / 1ps
interface mjq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [mjq_pkg::JobIdW-1:0]   result_job;
  logic [mjq_pkg::CountW-1:0]   level_count;
  logic                         ignored;

  modport source (output valid, found, result_job, level_count, ignored, input ready);
  modport sink   (input valid, found, result_job, level_count, ignored, output ready);
endinterface

FILE: src/mjq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module mjq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/multilevel_job_queue_top.sv
// Top level of the multilevel job queue: node memories, list tables and sequencer.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+----------------------------------------------
//   in_i    | in  | valid / ready  | command, job_id, priority_req, sub_priority
//   out_o   | out | valid / ready  | found, result_job, level_count, ignored
//
// One item at a time. Push and erase read the node, write node and list,
// patch a neighbor link when one must change, then load the result.
// Top, next and first-of-level read the node, then scan the lists in turn
// (up to 2*LEVEL_COUNT) for a non-empty one. Count sums the level's two sizes.
// After reset a clearing pass over all JOB_COUNT nodes zeros the queued flags;
// in_i.ready stays low until it ends.
// A waiting result in the output register does not block acceptance; the
// next result waits in the finishing step until out_o.ready frees the register.
`timescale 1ns / 1ps
module multilevel_job_queue_top #(
  parameter int unsigned JOB_COUNT   = 256,
  parameter int unsigned LEVEL_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mjq_in_if.sink    in_i,
  mjq_out_if.source out_o
);

  // Widths that follow from the parameters.
  localparam int unsigned JW     = $clog2(JOB_COUNT);
  localparam int unsigned NW     = JW + 1;                       // link, with null
  localparam int unsigned LVW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int unsigned LW     = LVW + 1;                      // list index
  localparam int unsigned NL     = 2 * LEVEL_COUNT;
  localparam int unsigned SW     = $clog2(JOB_COUNT + 1);
  localparam int unsigned NODE_W = 1 + LVW + 1 + NW;             // {queued, level, sub, next}

  localparam logic [NW-1:0] Nil     = NW'(JOB_COUNT);
  localparam logic [JW-1:0] LastJob = JW'(JOB_COUNT - 1);
  localparam logic [LW:0]   NlEnd   = (LW + 1)'(NL);

  // Sequencer states.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic [JW-1:0] clr_q, clr_d;

  // Latched command.
  mjq_pkg::cmd_e           cmd_q;
  logic [7:0]              job_q;
  logic [2:0]              lvl_q;
  logic [1:0]              sub_q;

  // Pending result.
  logic                    rfound_q, rfound_d;
  logic [JW-1:0]           rjob_q, rjob_d;
  logic [SW:0]             rcnt_q, rcnt_d;
  logic                    rign_q, rign_d;

  // Neighbor patch written in the fix state.
  logic                    fixn_en_q, fixn_en_d;
  logic [JW-1:0]           fixn_addr_q, fixn_addr_d;
  logic [NW-1:0]           fixn_val_q, fixn_val_d;
  logic                    fixp_en_q, fixp_en_d;
  logic [JW-1:0]           fixp_addr_q, fixp_addr_d;
  logic [NW-1:0]           fixp_val_q, fixp_val_d;

  // List scan.
  logic [LW:0]             scan_q, scan_d, scan_end_q, scan_end_d;

  // List tables, reset to empty.
  logic [NW-1:0]           head_q [NL];
  logic [NW-1:0]           tail_q [NL];
  logic [SW-1:0]           size_q [NL];

  logic                    lw_en;
  logic [LW-1:0]           lw_idx;
  logic [NW-1:0]           lw_head, lw_tail;
  logic [SW-1:0]           lw_size;

  // Output register.
  logic                    out_valid_q;
  logic                    out_found_q;
  logic [7:0]              out_job_q;
  logic [8:0]              out_cnt_q;
  logic                    out_ign_q;
  logic                    out_load;

  // Node memories.
  logic                    n_we, n_re, p_we, p_re;
  logic [JW-1:0]           n_waddr, n_raddr, p_waddr, p_raddr;
  logic [NODE_W-1:0]       n_wdata, n_rdata;
  logic [NW-1:0]           p_wdata, p_rdata;

  mjq_ram #(.Width(NODE_W), .Depth(JOB_COUNT)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  mjq_ram #(.Width(NW), .Depth(JOB_COUNT)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Decoded views of the latched command and the node just read.
  logic              in_acc;
  logic [JW+7:0]     in_job_ext, job_ext;
  logic [JW-1:0]     job_idx;
  logic [LVW+2:0]    lvl_ext;
  logic [LVW-1:0]    lvl_i;
  logic              job_ok, lvl_ok;
  logic              nq, nsub;
  logic [LVW-1:0]    nlvl;
  logic [NW-1:0]     nnext;
  logic [LW-1:0]     l_push, l_own, l_sel;
  logic [NW-1:0]     hd, tl;
  logic [SW-1:0]     sz;
  logic [NW-1:0]     scan_head;
  logic [LW:0]       scan_nxt;
  logic [LW:0]       own_p1, lvl_end;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_job_ext = {{JW{1'b0}}, in_i.job_id};
  assign job_ext    = {{JW{1'b0}}, job_q};
  assign job_idx    = job_ext[JW-1:0];
  assign lvl_ext    = {{LVW{1'b0}}, lvl_q};
  assign lvl_i      = lvl_ext[LVW-1:0];
  assign job_ok     = 32'(job_q) < JOB_COUNT;
  assign lvl_ok     = 32'(lvl_q) < LEVEL_COUNT;

  assign nq    = n_rdata[NODE_W-1];
  assign nlvl  = n_rdata[NODE_W-2 -: LVW];
  assign nsub  = n_rdata[NW];
  assign nnext = n_rdata[NW-1:0];

  assign l_push = {lvl_i, sub_q[1]};
  assign l_own  = {nlvl, nsub};
  assign l_sel  = (cmd_q == mjq_pkg::CMD_PUSH) ? l_push : l_own;
  assign hd     = head_q[l_sel];
  assign tl     = tail_q[l_sel];
  assign sz     = size_q[l_sel];

  assign scan_head = head_q[scan_q[LW-1:0]];
  assign scan_nxt  = scan_q + 1'b1;
  assign own_p1    = (LW + 1)'(l_own) + 1'b1;
  assign lvl_end   = (LW + 1)'({nlvl, 1'b1}) + 1'b1;

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rfound_d    = rfound_q;
    rjob_d      = rjob_q;
    rcnt_d      = rcnt_q;
    rign_d      = rign_q;
    fixn_en_d   = 1'b0;
    fixn_addr_d = fixn_addr_q;
    fixn_val_d  = fixn_val_q;
    fixp_en_d   = 1'b0;
    fixp_addr_d = fixp_addr_q;
    fixp_val_d  = fixp_val_q;
    scan_d      = scan_q;
    scan_end_d  = scan_end_q;
    n_we        = 1'b0;
    n_waddr     = job_idx;
    n_wdata     = '0;
    n_re        = 1'b0;
    n_raddr     = job_idx;
    p_we        = 1'b0;
    p_waddr     = job_idx;
    p_wdata     = Nil;
    p_re        = 1'b0;
    p_raddr     = job_idx;
    lw_en       = 1'b0;
    lw_idx      = l_sel;
    lw_head     = hd;
    lw_tail     = tl;
    lw_size     = sz;
    out_load    = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        // Sweep the node memory, clearing every queued flag.
        n_we    = 1'b1;
        n_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastJob) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          // Fetch the node of the named job; its data arrives next cycle.
          n_re     = 1'b1;
          p_re     = 1'b1;
          n_raddr  = in_job_ext[JW-1:0];
          p_raddr  = in_job_ext[JW-1:0];
          rfound_d = 1'b0;
          rjob_d   = '0;
          rcnt_d   = '0;
          rign_d   = 1'b0;
          state_d  = ST_RD;
        end
      end

      ST_RD: begin
        state_d = ST_DONE;
        unique case (cmd_q)
          mjq_pkg::CMD_PUSH: begin
            if (!job_ok || !lvl_ok || nq) begin
              rign_d = 1'b1;
            end else begin
              lw_en   = 1'b1;
              lw_size = sz + 1'b1;
              n_we    = 1'b1;
              p_we    = 1'b1;
              if (sub_q[0]) begin
                // Append at the back; patch the old tail's next link.
                n_wdata = {1'b1, lvl_i, sub_q[1], Nil};
                p_wdata = tl;
                lw_tail = NW'(job_idx);
                if (tl == Nil) begin
                  lw_head = NW'(job_idx);
                end else begin
                  n_re        = 1'b1;
                  n_raddr     = tl[JW-1:0];
                  fixn_en_d   = 1'b1;
                  fixn_addr_d = tl[JW-1:0];
                  fixn_val_d  = NW'(job_idx);
                  state_d     = ST_FIX;
                end
              end else begin
                // Insert at the front; patch the old head's prev link.
                n_wdata = {1'b1, lvl_i, sub_q[1], hd};
                p_wdata = Nil;
                lw_head = NW'(job_idx);
                if (hd == Nil) begin
                  lw_tail = NW'(job_idx);
                end else begin
                  fixp_en_d   = 1'b1;
                  fixp_addr_d = hd[JW-1:0];
                  fixp_val_d  = NW'(job_idx);
                  state_d     = ST_FIX;
                end
              end
            end
          end

          mjq_pkg::CMD_ERASE: begin
            if (!job_ok || !nq) begin
              rign_d = 1'b1;
            end else begin
              lw_en   = 1'b1;
              lw_size = (sz != '0) ? sz - 1'b1 : sz;
              n_we    = 1'b1;
              n_wdata = {1'b0, nlvl, nsub, nnext};
              if (nnext == Nil) begin
                lw_tail = p_rdata;
              end else begin
                p_we    = 1'b1;
                p_waddr = nnext[JW-1:0];
                p_wdata = p_rdata;
              end
              if (p_rdata == Nil) begin
                lw_head = nnext;
              end else begin
                n_re        = 1'b1;
                n_raddr     = p_rdata[JW-1:0];
                fixn_en_d   = 1'b1;
                fixn_addr_d = p_rdata[JW-1:0];
                fixn_val_d  = nnext;
                state_d     = ST_FIX;
              end
            end
          end

          mjq_pkg::CMD_TOP: begin
            scan_d     = '0;
            scan_end_d = NlEnd;
            state_d    = ST_SCAN;
          end

          mjq_pkg::CMD_NEXT, mjq_pkg::CMD_NEXTL: begin
            if (job_ok && nq) begin
              if (nnext != Nil) begin
                rfound_d = 1'b1;
                rjob_d   = nnext[JW-1:0];
              end else begin
                scan_d     = own_p1;
                scan_end_d = (cmd_q == mjq_pkg::CMD_NEXT) ? NlEnd : lvl_end;
                if (own_p1 < ((cmd_q == mjq_pkg::CMD_NEXT) ? NlEnd : lvl_end)) begin
                  state_d = ST_SCAN;
                end
              end
            end
          end

          mjq_pkg::CMD_FIRST: begin
            if (lvl_ok) begin
              scan_d     = (LW + 1)'({lvl_i, 1'b0});
              scan_end_d = (LW + 1)'({lvl_i, 1'b1}) + 1'b1;
              state_d    = ST_SCAN;
            end
          end

          mjq_pkg::CMD_COUNT: begin
            if (lvl_ok) begin
              rcnt_d = (SW + 1)'(size_q[{lvl_i, 1'b0}]) + (SW + 1)'(size_q[{lvl_i, 1'b1}]);
            end
          end

          default: begin
          end
        endcase
      end

      ST_FIX: begin
        // Rewrite the neighbor with its one link replaced.
        n_we    = fixn_en_q;
        n_waddr = fixn_addr_q;
        n_wdata = {n_rdata[NODE_W-1:NW], fixn_val_q};
        p_we    = fixp_en_q;
        p_waddr = fixp_addr_q;
        p_wdata = fixp_val_q;
        state_d = ST_DONE;
      end

      ST_SCAN: begin
        // One list per cycle until a non-empty one turns up or the range ends.
        if (scan_head != Nil) begin
          rfound_d = 1'b1;
          rjob_d   = scan_head[JW-1:0];
          state_d  = ST_DONE;
        end else if (scan_nxt >= scan_end_q) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_nxt;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  logic [JW+7:0] rjob_ext;
  logic [SW+9:0] rcnt_ext;
  assign rjob_ext = {8'b0, rjob_q};
  assign rcnt_ext = {9'b0, rcnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      fixn_en_q   <= 1'b0;
      fixp_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        head_q[i] <= Nil;
        tail_q[i] <= Nil;
        size_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fixn_en_q <= fixn_en_d;
      fixp_en_q <= fixp_en_d;
      if (lw_en) begin
        head_q[lw_idx] <= lw_head;
        tail_q[lw_idx] <= lw_tail;
        size_q[lw_idx] <= lw_size;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= mjq_pkg::cmd_e'(in_i.command);
      job_q <= in_i.job_id;
      lvl_q <= in_i.priority_req;
      sub_q <= in_i.sub_priority;
    end
    rfound_q    <= rfound_d;
    rjob_q      <= rjob_d;
    rcnt_q      <= rcnt_d;
    rign_q      <= rign_d;
    fixn_addr_q <= fixn_addr_d;
    fixn_val_q  <= fixn_val_d;
    fixp_addr_q <= fixp_addr_d;
    fixp_val_q  <= fixp_val_d;
    scan_q      <= scan_d;
    scan_end_q  <= scan_end_d;
    if (out_load) begin
      out_found_q <= rfound_q;
      out_job_q   <= rjob_ext[7:0];
      out_cnt_q   <= rcnt_ext[8:0];
      out_ign_q   <= rign_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.result_job  = out_job_q;
  assign out_o.level_count = out_cnt_q;
  assign out_o.ignored     = out_ign_q;

endmodule

FILE: src/mjq_checker.sv
// Port-level checks for the multilevel job queue, bound to the top level.
`timescale 1ns / 1ps
module mjq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       found_i,
  input logic [7:0] result_job_i,
  input logic [8:0] level_count_i,
  input logic       ignored_i
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // One item at a time: busy right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a second item while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> result_job_i == 8'd0)
    else $error("job id without found");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ignored_i |-> !found_i && level_count_i == 9'd0)
    else $error("ignored result carries query data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && level_count_i != 9'd0 |-> !found_i)
    else $error("count result carries a job");

endmodule

bind multilevel_job_queue_top mjq_checker u_mjq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_i       (out_o.found),
  .result_job_i  (out_o.result_job),
  .level_count_i (out_o.level_count),
  .ignored_i     (out_o.ignored)
);
